FILE: rtl/tkns_pkg.sv
// Shared types and constants for the top-k neighbour selector.
package tkns_pkg;

  localparam int TOP_MAX  = 64;
  localparam int ID_BITS  = 24;
  localparam int SIM_BITS = 16;
  localparam int CNT_W    = 7;
  localparam int CFG_W    = 24;

  localparam logic CFG_TOP_COUNT = 1'b0;
  localparam logic CFG_QUERY_ID  = 1'b1;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [SIM_BITS-1:0] sim;
    logic                same;
  } entry_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  cand_id;
    logic [SIM_BITS-1:0] similarity;
    logic                same_genome;
    logic                last_cand;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0]    rank;
    logic [ID_BITS-1:0]  out_id;
    logic [SIM_BITS-1:0] out_similarity;
    logic                out_same;
    logic [CNT_W-1:0]    same_so_far;
    logic [CNT_W-1:0]    first_hit_rank;
    logic                last_out;
  } out_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;    // insert the candidate, shifting weaker entries down
    logic shift;  // move every entry one cell toward the head
  } ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

endpackage

FILE: rtl/tkns_cell.sv
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
module tkns_cell (
  input  logic           clk_i,
  input  tkns_pkg::ctl_t ctl_i,
  input  tkns_pkg::entry_t cand_i,
  input  tkns_pkg::entry_t prev_i,
  input  logic           prev_take_i,
  input  tkns_pkg::entry_t next_i,
  input  logic           valid_i,
  output tkns_pkg::entry_t entry_o,
  output logic           take_o,
  output logic           beat_o
);

  tkns_pkg::entry_t entry_q, entry_d;

  // Candidate beats this entry: larger similarity, or smaller id on a tie.
  always_comb begin
    beat_o = (cand_i.sim > entry_q.sim) ||
             ((cand_i.sim == entry_q.sim) && (cand_i.id < entry_q.id));
  end

  // An empty cell counts as beaten, so the candidate lands in the first free slot.
  assign take_o = ~valid_i | beat_o;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = next_i;
    end else if (ctl_i.ins) begin
      if (prev_take_i) begin
        entry_d = prev_i;
      end else if (take_o) begin
        entry_d = cand_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/top_k_neighbour_selector_unit.sv
// Top level: control, configuration and output stage around the sorted cell chain.
// Each candidate is inserted into the sorted chain; one item per cycle while idle.
// After the last candidate the unit enters emit and registers results, head first,
// one per cycle while out_stall_i is low; input stalls until the last result is loaded.
// Reset (rst_ni low, async) empties the chain, sets top_count to 64, query_id to 0.
module top_k_neighbour_selector_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [tkns_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tkns_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tkns_pkg::out_t            out_data_o
);

  localparam int N = tkns_pkg::TOP_MAX;
  localparam int CW = tkns_pkg::CNT_W;

  logic [CW-1:0]               top_count_q;
  logic [tkns_pkg::ID_BITS-1:0] query_id_q;
  logic [CW-1:0]               count_q, count_d;
  logic [N-1:0]                valid_q, valid_d;
  tkns_pkg::state_e            state_q, state_d;
  logic [CW-1:0]               rank_q, rank_d;
  logic [CW-1:0]               same_q, same_d;
  logic [CW-1:0]               first_q, first_d;
  logic                        out_valid_q, out_valid_d;
  tkns_pkg::out_t              out_q, out_d;

  tkns_pkg::entry_t            cand;
  tkns_pkg::entry_t            cells [N];
  logic [N-1:0]                take;
  logic [N-1:0]                beat;
  tkns_pkg::ctl_t              ctl;

  logic [CW-1:0] limit;
  logic          in_acc, skip, full, any_beat, ins, emit_ld, grow;

  assign cand.id   = in_data_i.cand_id;
  assign cand.sim  = in_data_i.similarity;
  assign cand.same = in_data_i.same_genome;

  assign limit = (top_count_q > CW'(N)) ? CW'(N) : top_count_q;

  assign in_stall_o = (state_q != tkns_pkg::ST_IDLE);

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign skip     = (in_data_i.cand_id == query_id_q);
  assign full     = (count_q >= limit);
  // Chain is sorted, so beating any valid entry means beating the weakest one.
  assign any_beat = |(beat & valid_q);
  assign ins      = in_acc & ~skip & (~full | ((count_q != '0) & any_beat));
  assign grow     = ins & ~full;
  assign emit_ld  = (state_q == tkns_pkg::ST_EMIT) & (~out_valid_q | ~out_stall_i);

  assign ctl.ins   = ins;
  assign ctl.shift = emit_ld;

  for (genvar i = 0; i < N; i++) begin : g_cell
    tkns_pkg::entry_t prev_e, next_e;
    logic             prev_take;
    if (i == 0) begin : g_head
      assign prev_e    = '0;
      assign prev_take = 1'b0;
    end else begin : g_body
      assign prev_e    = cells[i-1];
      assign prev_take = take[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = cells[i+1];
    end
    tkns_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .cand_i      (cand),
      .prev_i      (prev_e),
      .prev_take_i (prev_take),
      .next_i      (next_e),
      .valid_i     (valid_q[i]),
      .entry_o     (cells[i]),
      .take_o      (take[i]),
      .beat_o      (beat[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= CW'(N);
      query_id_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tkns_pkg::CFG_TOP_COUNT: top_count_q <= cfg_wdata_i[CW-1:0];
        tkns_pkg::CFG_QUERY_ID:  query_id_q  <= cfg_wdata_i[tkns_pkg::ID_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    valid_d     = valid_q;
    rank_d      = rank_q;
    same_d      = same_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      tkns_pkg::ST_IDLE: begin
        if (grow) begin
          count_d = count_q + CW'(1);
          valid_d = {valid_q[N-2:0], 1'b1};
        end
        if (in_acc && in_data_i.last_cand && (count_d != '0)) begin
          state_d = tkns_pkg::ST_EMIT;
          rank_d  = CW'(1);
          same_d  = '0;
          first_d = '0;
        end
      end
      tkns_pkg::ST_EMIT: begin
        if (emit_ld) begin
          same_d  = same_q + CW'(cells[0].same);
          first_d = ((first_q == '0) && cells[0].same) ? rank_q : first_q;
          out_valid_d          = 1'b1;
          out_d.rank           = rank_q;
          out_d.out_id         = cells[0].id;
          out_d.out_similarity = cells[0].sim;
          out_d.out_same       = cells[0].same;
          out_d.same_so_far    = same_d;
          out_d.first_hit_rank = first_d;
          out_d.last_out       = (count_q == CW'(1));
          rank_d  = rank_q + CW'(1);
          count_d = count_q - CW'(1);
          valid_d = {1'b0, valid_q[N-1:1]};
          if (count_q == CW'(1)) begin
            state_d = tkns_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = tkns_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkns_pkg::ST_IDLE;
      count_q     <= '0;
      valid_q     <= '0;
      rank_q      <= '0;
      same_q      <= '0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      rank_q      <= rank_d;
      same_q      <= same_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the top-k neighbour selector unit.
`timescale 1ns / 1ps

module testbench;

  localparam int TOP_MAX = tkns_pkg::TOP_MAX;
  localparam int ID_W    = tkns_pkg::ID_BITS;
  localparam int SIM_W   = tkns_pkg::SIM_BITS;
  localparam int CNT_W   = tkns_pkg::CNT_W;
  localparam int CFG_W   = tkns_pkg::CFG_W;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = tkns_pkg::CFG_TOP_COUNT;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  tkns_pkg::in_t      in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  tkns_pkg::out_t     out_data_o;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  // Keeps its own sorted copy of the retained list and queues the ranked results
  // that each last candidate releases.
  class ranking_board;
    tkns_pkg::entry_t   kept[TOP_MAX];
    int unsigned        kept_n;
    int unsigned        top_count;
    logic [ID_W-1:0]    query_id;
    tkns_pkg::out_t     expected_ranks[$];
    int unsigned        mismatches;

    function new();
      kept_n = 0;
      top_count = TOP_MAX;
      query_id = '0;
      mismatches = 0;
    endfunction

    function void set_regs(int unsigned top, logic [ID_W-1:0] qid);
      top_count = top & 32'h7F;
      query_id = qid;
    endfunction

    function int unsigned waiting();
      return expected_ranks.size();
    endfunction

    // higher similarity first, smaller id breaks ties
    function bit beats(tkns_pkg::entry_t a, tkns_pkg::entry_t b);
      if (a.sim != b.sim) return a.sim > b.sim;
      return a.id < b.id;
    endfunction

    function void note_candidate(tkns_pkg::in_t d);
      tkns_pkg::entry_t c;
      tkns_pkg::out_t   o;
      int unsigned      lim, n, pos, k, same_n, first;
      bit               keep;
      c.id = d.cand_id;
      c.sim = d.similarity;
      c.same = d.same_genome;
      lim = (top_count > TOP_MAX) ? TOP_MAX : top_count;
      n = kept_n;
      keep = (c.id != query_id);
      // full (or over-full after a lowered count): only replace the weakest
      if (keep && n >= lim) begin
        if (n == 0 || !beats(c, kept[n-1])) keep = 1'b0;
        else n = n - 1;
      end
      if (keep && n < TOP_MAX) begin
        pos = 0;
        while (pos < n && !beats(c, kept[pos])) pos++;
        for (k = n; k > pos; k--) kept[k] = kept[k-1];
        kept[pos] = c;
        kept_n = n + 1;
      end
      if (!d.last_cand) return;
      same_n = 0;
      first = 0;
      for (k = 0; k < kept_n; k++) begin
        if (kept[k].same) begin
          same_n++;
          if (first == 0) first = k + 1;
        end
        o.rank = CNT_W'(k + 1);
        o.out_id = kept[k].id;
        o.out_similarity = kept[k].sim;
        o.out_same = kept[k].same;
        o.same_so_far = CNT_W'(same_n);
        o.first_hit_rank = CNT_W'(first);
        o.last_out = (k + 1 == kept_n);
        expected_ranks = {expected_ranks, o};
      end
      kept_n = 0;
    endfunction

    function void match(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_rank(tkns_pkg::out_t got);
      tkns_pkg::out_t want;
      if (expected_ranks.size() == 0) begin
        $error("unexpected result: rank %0d id %0d", got.rank, got.out_id);
        mismatches++;
        return;
      end
      want = expected_ranks.pop_front();
      match("rank", want.rank, got.rank);
      match("out_id", want.out_id, got.out_id);
      match("out_similarity", want.out_similarity, got.out_similarity);
      match("out_same", want.out_same, got.out_same);
      match("same_so_far", want.same_so_far, got.same_so_far);
      match("first_hit_rank", want.first_hit_rank, got.first_hit_rank);
      match("last_out", want.last_out, got.last_out);
    endfunction
  endclass

  ranking_board board;

  top_k_neighbour_selector_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_rank(out_data_o);
  end

  function automatic tkns_pkg::in_t cand(int unsigned id, int unsigned sim,
                                         int unsigned same, int unsigned last);
    tkns_pkg::in_t c;
    c.cand_id = ID_W'(id);
    c.similarity = SIM_W'(sim);
    c.same_genome = 1'(same);
    c.last_cand = 1'(last);
    return c;
  endfunction

  // small id and similarity pools in four of ten candidates so ties and duplicates are common
  function automatic tkns_pkg::in_t random_cand(int unsigned qid, bit last);
    int unsigned   style;
    tkns_pkg::in_t c;
    style = $urandom_range(9);
    c.same_genome = 1'($urandom_range(1));
    c.last_cand = last;
    c.similarity = SIM_W'($urandom);
    if (style == 0) begin
      c.cand_id = ID_W'(qid);
    end else if (style <= 4) begin
      c.cand_id = ID_W'($urandom_range(0, 15));
      c.similarity = SIM_W'($urandom_range(0, 3)) << (SIM_W - 2);
    end else begin
      c.cand_id = ID_W'($urandom);
    end
    return c;
  endfunction

  task automatic send(input tkns_pkg::in_t d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_candidate(d);
  endtask

  // writes both registers once the unit has drained and settled
  task automatic configure(input int unsigned top, input int unsigned qid);
    in_valid_i <= 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= tkns_pkg::CFG_TOP_COUNT;
    cfg_wdata_i <= CFG_W'(top & 32'h7F);
    @(posedge clk_i);
    cfg_idx_i <= tkns_pkg::CFG_QUERY_ID;
    cfg_wdata_i <= CFG_W'(qid);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_regs(top, ID_W'(qid));
  endtask

  task automatic run_directed();
    configure(3, 5);
    send(cand(5, 'hFFFF, 1, 0));              // own id: skipped
    send(cand(0, 'hFFFF, 1, 0));
    send(cand('hFFFFFF, 0, 0, 0));
    send(cand(7, 100, 1, 0));
    send(cand(3, 100, 0, 0));                 // replaces the weakest
    send(cand(8, 100, 0, 0));                 // tie lost on id
    send(cand(5, 0, 0, 1));                   // skipped last still emits
    configure(0, 0);
    send(cand(1, 10, 1, 0));
    send(cand(2, 20, 0, 1));                  // nothing retained
    configure(2, 'hABCDEF);
    send(cand('hABCDEF, 5, 1, 1));            // empty store at last
    configure(4, 9);
    send(cand(1, 50, 1, 0));
    send(cand(2, 60, 0, 0));
    send(cand(3, 40, 1, 0));
    send(cand(4, 70, 1, 0));
    configure(2, 9);                          // lowered below the fill level
    send(cand(5, 30, 0, 0));
    send(cand(6, 65, 1, 0));
    send(cand(7, 65, 0, 1));
    configure(1, 0);
    send(cand(10, 50, 0, 0));
    send(cand(10, 50, 1, 0));                 // equal entry is not better
    send(cand(20, 40, 0, 1));
    configure(127, 0);                        // saturates to TOP_MAX
    send(cand('h555555, 'hAAAA, 0, 0));
    send(cand('hAAAAAA, 'h5555, 1, 1));
  endtask

  task automatic run_random();
    int unsigned sent, nq, len, j, top, r, phase, qid;
    sent = 0;
    nq = 0;
    while (sent < 140) begin
      phase = sent * 4 / 140;
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 56; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      r = $urandom_range(99);
      if (r < 60)      top = $urandom_range(1, 6);
      else if (r < 72) top = $urandom_range(7, 20);
      else if (r < 80) top = 0;
      else if (r < 88) top = TOP_MAX;
      else             top = $urandom_range(65, 127);
      qid = ($urandom_range(1) != 0) ? $urandom_range(0, 'hFFFFFF) : $urandom_range(0, 15);
      len = $urandom_range(1, 12);
      // one query that overfills a saturated store
      if (nq == 3) begin
        top = 100;
        len = 70;
      end
      configure(top, qid);
      for (j = 0; j < len; j++) begin
        if (len > 3 && j == len / 2 && $urandom_range(3) == 0)
          configure($urandom_range(0, 3), qid);
        send(random_cand(qid, j == len - 1));
      end
      sent += len;
      nq++;
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid_i <= 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0 && board.waiting() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
